[hdl/msrf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// msrf_pkg
// Types, codes and sizes shared by the monitor status repetition filter.
// ----------------------------------------------------------------------------
package msrf_pkg;

	localparam int MON_COUNT = 32;
	localparam int MON_IDX_W = $clog2(MON_COUNT);
	localparam int LOG_DEPTH = 16;
	localparam int LOG_CNT_W = $clog2(LOG_DEPTH + 1);
	localparam int SLOT_W    = 4;

	localparam logic [7:0] REP_MAX = 8'hFF;

	typedef enum logic [1:0] {
		OP_DEFINE  = 2'd0,
		OP_UNCHECK = 2'd1,
		OP_REPORT  = 2'd2
	} op_t;

	typedef logic [1:0] status_t;
	localparam status_t ST_UNCHECKED = 2'd0;

	typedef logic [1:0] mon_type_t;
	localparam mon_type_t MT_LIMIT    = 2'd1;
	localparam mon_type_t MT_EXPECTED = 2'd2;

	typedef struct packed {
		op_t         operation;
		logic [4:0]  monitor_index;
		mon_type_t   monitor_type;
		logic [7:0]  repetition_needed;
		status_t     observed_status;
		logic [31:0] sample_value;
		logic [31:0] reference_value;
		logic [31:0] current_time;
	} item_t;

	typedef struct packed {
		logic        transition;
		logic [4:0]  record_monitor;
		status_t     previous_status;
		status_t     confirmed_status;
		logic [31:0] record_value;
		logic [31:0] record_reference;
		logic [31:0] first_seen_time;
		logic [3:0]  log_slot;
		logic        report_due;
	} result_t;

	typedef struct packed {
		mon_type_t   mtype;
		logic [7:0]  repetition;
		status_t     confirmed;
		status_t     candidate;
		logic [7:0]  repeat_count;
		logic [31:0] first_seen;
	} entry_t;

	function automatic logic type_checked(input mon_type_t t);
		return (t == MT_LIMIT) || (t == MT_EXPECTED);
	endfunction

endpackage
`default_nettype wire

[hdl/monitor_status_repetition_filter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// monitor_status_repetition_filter
// Table of parameter monitors that confirms a new status only after it has
// been reported the configured number of times, and emits transition records.
// ----------------------------------------------------------------------------
// usage:
//  item channel (item_valid / item_stall / item) carries define, mark
//  unchecked and report operations; every accepted beat yields exactly one
//  result beat on result_valid / result_stall / result, all zero unless
//  the report confirmed a status change.
//  timing: an accepted beat is registered in the input register, and its
//  result is registered in the result register when it advances there.
//  throughput: one beat per cycle unless stalled; the table entry is read,
//  updated and written back in the single stage after the input register.
//  stall: while result_stall holds a waiting result, an empty input register
//  still takes one more beat, then item_stall rises until the result moves.
//  reset: arst_n clears the whole table (all monitors undefined, unchecked,
//  counters zero), the log counter and both valid flags; the block is usable
//  on the first cycle after reset.
// ----------------------------------------------------------------------------
module monitor_status_repetition_filter
	import msrf_pkg::*;
(
	input  var logic    clk,
	input  var logic    arst_n,
	input  var logic    item_valid,
	output logic        item_stall,
	input  var item_t   item,
	output logic        result_valid,
	input  var logic    result_stall,
	output result_t     result
);

	logic                 item_valid_s1;
	item_t                item_s1;
	logic                 result_valid_q;
	result_t              result_q;
	entry_t               entry_q [MON_COUNT];
	logic [LOG_CNT_W-1:0] log_count_q;

	logic                 adv;
	logic                 in_range;
	logic [MON_IDX_W-1:0] idx;
	entry_t               entry_nxt;
	logic [LOG_CNT_W-1:0] log_count_nxt;
	result_t              record;

	assign adv        = item_valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = item_valid_s1 && !adv;
	assign idx        = item_s1.monitor_index[MON_IDX_W-1:0];
	assign in_range   = 32'(item_s1.monitor_index) < 32'(MON_COUNT);

	msrf_update u_update (
		.item          (item_s1),
		.entry         (entry_q[idx]),
		.log_count     (log_count_q),
		.entry_nxt     (entry_nxt),
		.log_count_nxt (log_count_nxt),
		.record        (record)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			item_valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
	end

	// monitor table and log counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MON_COUNT; i++) begin
				entry_q[i] <= '0;
			end
			log_count_q <= '0;
		end else if (adv && in_range) begin
			entry_q[idx] <= entry_nxt;
			log_count_q  <= log_count_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_q <= in_range ? record : '0;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (item_valid_s1 && result_valid_q && result_stall))
		else $error("input stalled without a blocked result");

	a_log_bound: assert property (@(posedge clk) disable iff (!arst_n)
		log_count_q < LOG_CNT_W'(LOG_DEPTH))
		else $error("log counter out of range");

	a_quiet_result: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && !result_q.transition) |->
		(!result_q.report_due && result_q.first_seen_time == '0))
		else $error("non-transition result carries record data");

	a_due_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && in_range && record.report_due) |=> (log_count_q == '0))
		else $error("log counter did not wrap on report due");

endmodule
`default_nettype wire

[hdl/msrf_update.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// msrf_update
// Next state of one monitor entry and of the log counter, plus the
// transition record, for one operation.
// ----------------------------------------------------------------------------
module msrf_update
	import msrf_pkg::*;
(
	input  var item_t                 item,
	input  var entry_t                entry,
	input  var logic [LOG_CNT_W-1:0]  log_count,
	output entry_t                    entry_nxt,
	output logic [LOG_CNT_W-1:0]      log_count_nxt,
	output result_t                   record
);

	logic                 checked;
	logic [7:0]           cnt_seen;
	status_t              cand_seen;
	logic [31:0]          fs_seen;
	logic [LOG_CNT_W-1:0] log_inc;

	assign log_inc = log_count + LOG_CNT_W'(1);

	always_comb begin
		entry_nxt     = entry;
		log_count_nxt = log_count;
		record        = '0;
		checked       = type_checked(entry.mtype);
		cnt_seen      = entry.repeat_count;
		cand_seen     = entry.candidate;
		fs_seen       = entry.first_seen;
		case (item.operation)
			OP_DEFINE: begin
				entry_nxt.mtype      = item.monitor_type;
				entry_nxt.repetition = item.repetition_needed;
				if (type_checked(item.monitor_type)) begin
					entry_nxt.confirmed = ST_UNCHECKED;
				end
				entry_nxt.candidate = entry_nxt.confirmed;
			end
			OP_UNCHECK: begin
				if (checked) begin
					entry_nxt.confirmed = ST_UNCHECKED;
				end
				entry_nxt.candidate = entry_nxt.confirmed;
			end
			OP_REPORT: begin
				if (!(checked && entry.confirmed == item.observed_status)) begin
					if (checked && entry.candidate == item.observed_status) begin
						cnt_seen = (entry.repeat_count == REP_MAX) ? entry.repeat_count
							: entry.repeat_count + 8'd1;
					end else begin
						cand_seen = item.observed_status;
						cnt_seen  = 8'd1;
						fs_seen   = item.current_time;
					end
					entry_nxt.candidate    = cand_seen;
					entry_nxt.repeat_count = cnt_seen;
					entry_nxt.first_seen   = fs_seen;
					if (cnt_seen >= entry.repetition) begin
						record.transition       = 1'b1;
						record.record_monitor   = item.monitor_index;
						record.previous_status  = entry.confirmed;
						record.confirmed_status = item.observed_status;
						record.record_value     = item.sample_value;
						record.record_reference = item.reference_value;
						record.first_seen_time  = fs_seen;
						record.log_slot         = log_count[SLOT_W-1:0];
						if (log_inc >= LOG_CNT_W'(LOG_DEPTH)) begin
							record.report_due = 1'b1;
							log_count_nxt     = '0;
						end else begin
							log_count_nxt = log_inc;
						end
						entry_nxt.repeat_count = '0;
						entry_nxt.confirmed    = item.observed_status;
					end
				end else begin
					entry_nxt.candidate    = item.observed_status;
					entry_nxt.repeat_count = '0;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire
